/* rtl/iira_pkg.sv */
// shared types and constants for the indexed insert/remove array
// request and status codes, field widths, cell control group; no dependencies
package iira_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int CNT_OUT_W    = 7;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_WRITE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic load;
	} cell_ctl_t;

endpackage

/* rtl/iira_cell.sv */
// one storage cell of the entry row
// depends on iira_pkg; compares the broadcast position with its own index
module iira_cell import iira_pkg::*; #(
	parameter int CMP_W = 7,
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [CMP_W-1:0]  pos,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] rd_data
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;
	logic              hit;
	logic              above;

	assign hit   = (pos == MY_IDX);
	assign above = (pos < MY_IDX);

	always_comb begin
		data_d = data_q;
		if (ctl.shift_up && above) begin
			data_d = left_data;
		end else if (ctl.shift_down && (above || hit)) begin
			data_d = right_data;
		end else if (ctl.load && hit) begin
			data_d = value;
		end
	end

	// entry payload, undefined until written
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	assign rd_data = hit ? data_q : '0;

endmodule

/* rtl/iira_ctrl.sv */
// request decode, range and full checks, entry count register
// depends on iira_pkg; drives the cell control group
module iira_ctrl import iira_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int CMP_W    = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       req_type,
	input  logic [POS_W-1:0] position,
	output cell_ctl_t        ctl,
	output logic [CMP_W-1:0] pos_ext,
	output status_t          status,
	output logic [CMP_W-1:0] count_next,
	output logic             rd_en
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] count_ext;
	req_t             req;
	logic             ok;

	assign req       = req_t'(req_type);
	assign pos_ext   = CMP_W'(position);
	assign count_ext = CMP_W'(count_q);

	always_comb begin
		status = ST_OK;
		case (req)
			REQ_INSERT: begin
				if (pos_ext > count_ext) begin
					status = ST_RANGE;
				end else if (count_ext >= CAP_C) begin
					status = ST_FULL;
				end
			end
			default: begin
				if (pos_ext >= count_ext) begin
					status = ST_RANGE;
				end
			end
		endcase
		ok = accept && (status == ST_OK);

		ctl.shift_up   = ok && (req == REQ_INSERT);
		ctl.shift_down = ok && (req == REQ_REMOVE);
		ctl.load       = ok && ((req == REQ_INSERT) || (req == REQ_WRITE));
		rd_en          = ok && (req == REQ_READ);

		count_next = count_ext;
		if (ctl.shift_up) begin
			count_next = count_ext + CMP_W'(1);
		end else if (ctl.shift_down) begin
			count_next = count_ext - CMP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next[CNT_W-1:0];
		end
	end

endmodule

/* rtl/indexed_insert_remove_array_core.sv */
// top level of the indexed insert/remove array: a row of entry cells
// depends on iira_pkg, iira_ctrl and iira_cell
//
// Ordered list of signed 32-bit entries in a row of CAPACITY cells. A request
// is taken at any clock edge where start is high and busy is low; busy stays
// low, so one item can be issued every cycle. Every cell moves to its neighbor
// in the same cycle, so an insert or remove takes one cycle whatever the
// position. The result appears one cycle after the item is taken, for exactly
// one cycle with done high, and must be captured then: it cannot be held off.
// A failing request (status range or full) changes nothing. read_value is zero
// except for a successful read; entry_count is the count after the request.
module indexed_insert_remove_array_core import iira_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               req_type,
	input  logic [POS_W-1:0]         position,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_OUT_W-1:0]     entry_count,
	output logic [1:0]               status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int OUT_W = (CMP_W > CNT_OUT_W) ? CMP_W : CNT_OUT_W;

	logic              accept;
	cell_ctl_t         ctl;
	logic [CMP_W-1:0]  pos_ext;
	status_t           st;
	logic [CMP_W-1:0]  count_next;
	logic              rd_en;
	logic [OUT_W-1:0]  count_wide;

	logic [DATA_W-1:0] data_w [CAPACITY];
	logic [DATA_W-1:0] rd_w   [CAPACITY];
	logic [DATA_W-1:0] rd_or;

	logic                 done_q;
	logic [DATA_W-1:0]    read_value_q;
	logic [CNT_OUT_W-1:0] entry_count_q;
	status_t              status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	iira_ctrl #(
		.CAPACITY(CAPACITY),
		.CMP_W   (CMP_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req_type),
		.position  (position),
		.ctl       (ctl),
		.pos_ext   (pos_ext),
		.status    (st),
		.count_next(count_next),
		.rd_en     (rd_en)
	);

	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (j == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = data_w[j-1];
		end
		// the cell freed at the top end of a remove takes zero
		if (j == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = data_w[j+1];
		end

		iira_cell #(
			.CMP_W(CMP_W),
			.INDEX(j)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.pos       (pos_ext),
			.value     (value),
			.left_data (left_d),
			.right_data(right_d),
			.data      (data_w[j]),
			.rd_data   (rd_w[j])
		);
	end

	// only the addressed cell drives nonzero read data
	always_comb begin
		rd_or = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			rd_or = rd_or | rd_w[j];
		end
	end

	assign count_wide = OUT_W'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= rd_en ? rd_or : '0;
			entry_count_q <= count_wide[CNT_OUT_W-1:0];
			status_q      <= st;
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

endmodule
